// ===== sv/pcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Clock manager register file package
// Register word indexes, reset values and the decode struct shared by the
// decoder and the top level.
// ----------------------------------------------------------------------------
package pcm_pkg;

   // word indexes (byte offset / 4)
   localparam logic [4:0] IX_SCER = 5'd0;
   localparam logic [4:0] IX_SCDR = 5'd1;
   localparam logic [4:0] IX_SCSR = 5'd2;
   localparam logic [4:0] IX_PCER = 5'd4;
   localparam logic [4:0] IX_PCDR = 5'd5;
   localparam logic [4:0] IX_PCSR = 5'd6;
   localparam logic [4:0] IX_MOR  = 5'd8;
   localparam logic [4:0] IX_MCFR = 5'd9;
   localparam logic [4:0] IX_PLLA = 5'd10;
   localparam logic [4:0] IX_PLLB = 5'd11;
   localparam logic [4:0] IX_MCKR = 5'd12;
   localparam logic [4:0] IX_PCK0 = 5'd16;
   localparam logic [4:0] IX_PCK1 = 5'd17;
   localparam logic [4:0] IX_PCK2 = 5'd18;
   localparam logic [4:0] IX_PCK3 = 5'd19;
   localparam logic [4:0] IX_IER  = 5'd24;
   localparam logic [4:0] IX_IDR  = 5'd25;
   localparam logic [4:0] IX_SR   = 5'd26;
   localparam logic [4:0] IX_IMR  = 5'd27;

   // access kinds
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // main clock frequency word: ready flag in bit 16, count 0x708
   localparam logic [31:0] MAIN_FREQ_WORD = 32'h0001_0000 | (32'h0000_0708 & 32'h0000_ffff);

   // reset values
   localparam logic [31:0] RST_SCSR = 32'h0000_0001;
   localparam logic [31:0] RST_PLLA = 32'h0000_3f00 | 32'h0000_0003 | (32'd28 << 16);
   localparam logic [31:0] RST_PLLB = 32'h0000_3f00;
   localparam logic [31:0] RST_MCKR = 32'h0000_0202;

   // status bits in the ready status word
   localparam int unsigned SR_MOSCS = 0;
   localparam int unsigned SR_LOCKA = 1;
   localparam int unsigned SR_LOCKB = 2;
   localparam int unsigned SR_MCKRDY = 3;

   // write strobes from the address decoder
   typedef struct packed {
      logic scer;
      logic scdr;
      logic pcer;
      logic pcdr;
      logic mor;
      logic plla;
      logic pllb;
      logic mckr;
      logic pck;
      logic ier;
      logic idr;
      logic bad;
   } pcm_wsel_type;

endpackage

// ===== sv/power_clock_manager_registers.sv =====
// ----------------------------------------------------------------------------
// Clock manager register file
// Bus-access front end of a power management controller clock manager.
// ----------------------------------------------------------------------------
// Takes one access word per cycle and returns one response word per access,
// in order. The request lands in an input register, and the register file
// is read and updated as the word moves on to the response register. Reads
// of unmapped or write-only words return 0; writes to
// unmapped or read-only words change nothing and set bad_write. irq_pulse is
// set when an oscillator or PLL write (or an interrupt enable) fires an event
// whose mask bit is clear. Both sides may stall at any time.
module power_clock_manager_registers (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [4:0] reg_index, [36:5] write_data, rest zero
   input  logic        req_tuser,   // kind: 0 read, 1 write
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] read_data, [32] bad_write, [33] irq_pulse
);

   // input register
   logic        req_vld_ff;
   logic        kind_ff;
   logic [4:0]  index_ff;
   logic [31:0] wdata_ff;

   // response register
   logic        rsp_vld_ff;
   logic [31:0] rdata_ff, rdata_in;
   logic        bad_ff;
   logic        irq_ff, irq_in;

   // register file
   logic [31:0] scsr_ff, scsr_in;
   logic [31:0] pcsr_ff, pcsr_in;
   logic [31:0] mor_ff,  mor_in;
   logic [31:0] mcfr_ff, mcfr_in;
   logic [31:0] plla_ff, plla_in;
   logic [31:0] pllb_ff, pllb_in;
   logic [31:0] mckr_ff, mckr_in;
   logic [31:0] pck_ff [4];
   logic [31:0] sr_ff,   sr_in;
   logic [31:0] imr_ff,  imr_in;

   logic                  rsp_load;
   logic                  advance;
   pcm_pkg::pcm_wsel_type wsel;

   // handshake: response register loads when empty or being drained
   assign rsp_load   = !rsp_vld_ff || rsp_tready;
   assign advance    = req_vld_ff && rsp_load;
   assign req_tready = !req_vld_ff || rsp_load;

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'b0, irq_ff, bad_ff, rdata_ff};

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req_tready) begin
         req_vld_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         kind_ff  <= req_tuser;
         index_ff <= req_tdata[4:0];
         wdata_ff <= req_tdata[36:5];
      end
   end

   // write decode, gated by the word actually moving on
   pcm_decode u_decode (
      .wr_en     (advance && kind_ff == pcm_pkg::KIND_WRITE),
      .reg_index (index_ff),
      .wsel      (wsel)
   );

   // read mux
   always_comb begin
      rdata_in = '0;
      if (kind_ff == pcm_pkg::KIND_READ) begin
         unique case (index_ff)
            pcm_pkg::IX_SCSR: rdata_in = scsr_ff;
            pcm_pkg::IX_PCSR: rdata_in = pcsr_ff;
            pcm_pkg::IX_MOR:  rdata_in = mor_ff;
            pcm_pkg::IX_MCFR: rdata_in = mcfr_ff;
            pcm_pkg::IX_PLLA: rdata_in = plla_ff;
            pcm_pkg::IX_PLLB: rdata_in = pllb_ff;
            pcm_pkg::IX_MCKR: rdata_in = mckr_ff;
            pcm_pkg::IX_PCK0, pcm_pkg::IX_PCK1,
            pcm_pkg::IX_PCK2, pcm_pkg::IX_PCK3: rdata_in = pck_ff[index_ff[1:0]];
            pcm_pkg::IX_SR:   rdata_in = sr_ff;
            pcm_pkg::IX_IMR:  rdata_in = imr_ff;
            default:          rdata_in = '0;
         endcase
      end
   end

   // register file next state and interrupt event
   always_comb begin
      scsr_in = scsr_ff;
      pcsr_in = pcsr_ff;
      mor_in  = mor_ff;
      mcfr_in = mcfr_ff;
      plla_in = plla_ff;
      pllb_in = pllb_ff;
      mckr_in = mckr_ff;
      sr_in   = sr_ff;
      imr_in  = imr_ff;
      irq_in  = 1'b0;

      if (wsel.scer) scsr_in = scsr_ff | wdata_ff;
      if (wsel.scdr) scsr_in = scsr_ff & ~wdata_ff;
      if (wsel.pcer) pcsr_in = pcsr_ff | wdata_ff;
      if (wsel.pcdr) pcsr_in = pcsr_ff & ~wdata_ff;

      // oscillator: enable marks ready and sets the frequency word, disable clears ready
      if (wsel.mor) begin
         mor_in = wdata_ff;
         if (wdata_ff[0]) begin
            sr_in[pcm_pkg::SR_MOSCS] = 1'b1;
            irq_in  = !imr_ff[pcm_pkg::SR_MOSCS];
            mcfr_in = mcfr_ff | pcm_pkg::MAIN_FREQ_WORD;
         end else begin
            sr_in[pcm_pkg::SR_MOSCS] = 1'b0;
         end
      end

      // PLLs lock at once
      if (wsel.plla) begin
         plla_in = wdata_ff;
         sr_in[pcm_pkg::SR_LOCKA] = 1'b1;
         irq_in = !imr_ff[pcm_pkg::SR_LOCKA];
      end
      if (wsel.pllb) begin
         pllb_in = wdata_ff;
         sr_in[pcm_pkg::SR_LOCKB] = 1'b1;
         irq_in = !imr_ff[pcm_pkg::SR_LOCKB];
      end

      if (wsel.mckr) mckr_in = wdata_ff;

      // interrupt mask set / clear
      if (wsel.ier) begin
         irq_in = !sr_ff[pcm_pkg::SR_MCKRDY] && wdata_ff[pcm_pkg::SR_MCKRDY]
                  && !imr_ff[pcm_pkg::SR_MCKRDY];
         imr_in = imr_ff | wdata_ff;
      end
      if (wsel.idr) imr_in = imr_ff & ~wdata_ff;
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         scsr_ff   <= pcm_pkg::RST_SCSR;
         pcsr_ff   <= '0;
         mor_ff    <= '0;
         mcfr_ff   <= '0;
         plla_ff   <= pcm_pkg::RST_PLLA;
         pllb_ff   <= pcm_pkg::RST_PLLB;
         mckr_ff   <= pcm_pkg::RST_MCKR;
         pck_ff[0] <= '0;
         pck_ff[1] <= '0;
         pck_ff[2] <= '0;
         pck_ff[3] <= '0;
         sr_ff     <= '0;
         imr_ff    <= '0;
      end else begin
         scsr_ff <= scsr_in;
         pcsr_ff <= pcsr_in;
         mor_ff  <= mor_in;
         mcfr_ff <= mcfr_in;
         plla_ff <= plla_in;
         pllb_ff <= pllb_in;
         mckr_ff <= mckr_in;
         sr_ff   <= sr_in;
         imr_ff  <= imr_in;
         if (wsel.pck) begin
            pck_ff[index_ff[1:0]] <= wdata_ff;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_vld_ff <= req_vld_ff;
      end
      if (advance) begin
         rdata_ff <= rdata_in;
         bad_ff   <= wsel.bad;
         irq_ff   <= irq_in;
      end
   end

endmodule

// ===== sv/pcm_decode.sv =====
// ----------------------------------------------------------------------------
// Clock manager write decoder
// Turns a word index and write enable into one write strobe per register (one
// for all four PCK words), or the bad-write flag for unmapped or read-only words.
// ----------------------------------------------------------------------------
module pcm_decode (
   input  logic                  wr_en,
   input  logic [4:0]            reg_index,
   output pcm_pkg::pcm_wsel_type wsel
);

   always_comb begin
      wsel = '0;
      if (wr_en) begin
         unique case (reg_index)
            pcm_pkg::IX_SCER: wsel.scer = 1'b1;
            pcm_pkg::IX_SCDR: wsel.scdr = 1'b1;
            pcm_pkg::IX_PCER: wsel.pcer = 1'b1;
            pcm_pkg::IX_PCDR: wsel.pcdr = 1'b1;
            pcm_pkg::IX_MOR:  wsel.mor  = 1'b1;
            pcm_pkg::IX_PLLA: wsel.plla = 1'b1;
            pcm_pkg::IX_PLLB: wsel.pllb = 1'b1;
            pcm_pkg::IX_MCKR: wsel.mckr = 1'b1;
            pcm_pkg::IX_PCK0, pcm_pkg::IX_PCK1,
            pcm_pkg::IX_PCK2, pcm_pkg::IX_PCK3: wsel.pck = 1'b1;
            pcm_pkg::IX_IER:  wsel.ier  = 1'b1;
            pcm_pkg::IX_IDR:  wsel.idr  = 1'b1;
            default:          wsel.bad  = 1'b1;
         endcase
      end
   end

endmodule
